/* src/ohi_pkg.sv */
package ohi_pkg;

	localparam int MAX_RECORDS = 1024;
	localparam int IDX_W = $clog2(MAX_RECORDS);
	localparam int CNT_W = IDX_W + 1;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Every intermediate value is held within plus or minus this bound.
	localparam logic signed [63:0] LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic start;
		logic is_div;
		logic sh30;
	} ohi_op_t;

	function automatic logic signed [63:0] ohi_sadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		logic signed [64:0] lim65;
		s = {a[63], a} + {b[63], b};
		lim65 = {LIM[63], LIM};
		if (s > lim65) begin
			return LIM;
		end else if (s < -lim65) begin
			return -LIM;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [39:0] ohi_clamp40(input logic signed [63:0] v);
		if (v > 64'sh0000_007F_FFFF_FFFF) begin
			return 40'sh7F_FFFF_FFFF;
		end else if (v < -64'sh0000_0080_0000_0000) begin
			return 40'sh80_0000_0000;
		end
		return v[39:0];
	endfunction

	function automatic logic signed [63:0] ohi_sx40(input logic signed [39:0] v);
		return {{24{v[39]}}, v};
	endfunction

endpackage

/* src/ohi_ram.sv */
module ohi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* src/ohi_arith.sv */
module ohi_arith (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ohi_pkg::ohi_op_t     op,
	input  logic signed [63:0]   opa,
	input  logic signed [63:0]   opb,
	output logic signed [63:0]   res,
	output logic                 done
);
	import ohi_pkg::*;

	localparam logic [2:0] A_IDLE = 3'd0;
	localparam logic [2:0] A_MUL  = 3'd1;
	localparam logic [2:0] A_MFIN = 3'd2;
	localparam logic [2:0] A_DIV  = 3'd3;
	localparam logic [2:0] A_DFIN = 3'd4;

	logic [2:0]          st_q;
	logic [63:0]         ua_q, ub_q;
	logic                neg_q, sh30_q;
	logic [127:0]        acc_q;
	logic [2:0]          pcnt_q;
	logic [63:0]         pp_s1;
	logic [1:0]          ppsh_s1;
	logic                ppv_s1;
	logic [92:0]         dvd_q;
	logic [47:0]         den_q, rem_q;
	logic [61:0]         quo_q;
	logic                sat_q;
	logic [6:0]          dcnt_q;
	logic signed [63:0]  res_q;
	logic                done_q;

	logic [63:0]  mag_a, mag_b;
	logic [31:0]  a_half, b_half;
	logic [63:0]  pp_d;
	logic [127:0] rnd, shf;
	logic [63:0]  mm, dm;
	logic [48:0]  trial, diff;
	logic         ge;

	assign mag_a  = opa[63] ? 64'(-opa) : 64'(opa);
	assign mag_b  = opb[63] ? 64'(-opb) : 64'(opb);
	assign a_half = pcnt_q[1] ? ua_q[63:32] : ua_q[31:0];
	assign b_half = pcnt_q[0] ? ub_q[63:32] : ub_q[31:0];
	assign pp_d   = a_half * b_half;

	// Round half away from zero on the magnitude, then saturate.
	assign rnd = acc_q + (sh30_q ? 128'h2000_0000 : 128'h8000);
	assign shf = sh30_q ? (rnd >> 30) : (rnd >> 16);
	assign mm  = (|shf[127:62]) ? 64'(LIM) : {2'b00, shf[61:0]};
	assign dm  = sat_q ? 64'(LIM) : {2'b00, quo_q};

	assign trial = {rem_q, dvd_q[92]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= A_IDLE;
			done_q <= 1'b0;
			ppv_s1 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				A_IDLE: begin
					if (op.start) begin
						st_q <= op.is_div ? A_DIV : A_MUL;
					end
				end
				A_MUL: begin
					ppv_s1 <= pcnt_q != 3'd4;
					if (pcnt_q == 3'd4) begin
						st_q <= A_MFIN;
					end
				end
				A_MFIN: begin
					st_q   <= A_IDLE;
					done_q <= 1'b1;
					ppv_s1 <= 1'b0;
				end
				A_DIV: begin
					if (dcnt_q == 7'd1) begin
						st_q <= A_DFIN;
					end
				end
				A_DFIN: begin
					st_q   <= A_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			A_IDLE: begin
				ua_q   <= mag_a;
				ub_q   <= mag_b;
				neg_q  <= op.is_div ? opa[63] : (opa[63] != opb[63]);
				sh30_q <= op.sh30;
				acc_q  <= '0;
				pcnt_q <= '0;
				// The dividend is left-aligned; the bit count sets the fraction width.
				dvd_q  <= {mag_a[62:0], 30'b0};
				den_q  <= opb[47:0];
				rem_q  <= '0;
				quo_q  <= '0;
				sat_q  <= 1'b0;
				dcnt_q <= op.sh30 ? 7'd93 : 7'd79;
			end
			A_MUL: begin
				if (pcnt_q != 3'd4) begin
					pp_s1   <= pp_d;
					ppsh_s1 <= 2'(pcnt_q[1]) + 2'(pcnt_q[0]);
					pcnt_q  <= pcnt_q + 3'd1;
				end
				if (ppv_s1) begin
					acc_q <= acc_q + (128'(pp_s1) << {ppsh_s1, 5'b0});
				end
			end
			A_MFIN: begin
				res_q <= neg_q ? -$signed(mm) : $signed(mm);
			end
			A_DIV: begin
				rem_q  <= ge ? diff[47:0] : trial[47:0];
				quo_q  <= {quo_q[60:0], ge};
				sat_q  <= sat_q | quo_q[61];
				dvd_q  <= dvd_q << 1;
				dcnt_q <= dcnt_q - 7'd1;
			end
			A_DFIN: begin
				res_q <= neg_q ? -$signed(dm) : $signed(dm);
			end
			default: ;
		endcase
	end

	assign res  = res_q;
	assign done = done_q;
endmodule

/* src/orbit_hermite_interpolator_top.sv */
// Orbit record table with cubic Hermite interpolation. A load request (cmd 0)
// appends a record while the table is not full, a clear request (cmd 2)
// empties the table, and a query request (cmd 1) returns interpolated position
// and velocity with a bracketed flag. A query's run time is set by the walk
// over the records it steps past, by the bit-serial divider (one quotient bit a
// cycle, used once for the normalised time and once per axis for velocity) and
// by the multiplier, which builds each 64-bit product from four 32x32 partial
// products. The table holds no valid bits and needs no clearing pass: only
// records below the fill count are read.
module orbit_hermite_interpolator_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [47:0]         sample_time,
	input  logic signed [39:0]  in_pos_x,
	input  logic signed [39:0]  in_pos_y,
	input  logic signed [39:0]  in_pos_z,
	input  logic signed [39:0]  in_vel_x,
	input  logic signed [39:0]  in_vel_y,
	input  logic signed [39:0]  in_vel_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [39:0]  out_pos_x,
	output logic signed [39:0]  out_pos_y,
	output logic signed [39:0]  out_pos_z,
	output logic signed [39:0]  out_vel_x,
	output logic signed [39:0]  out_vel_y,
	output logic signed [39:0]  out_vel_z,
	output logic                bracketed
);
	import ohi_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_W0   = 4'd1;
	localparam logic [3:0] S_W1   = 4'd2;
	localparam logic [3:0] S_W2   = 4'd3;
	localparam logic [3:0] S_F0   = 4'd4;
	localparam logic [3:0] S_F1   = 4'd5;
	localparam logic [3:0] S_F2   = 4'd6;
	localparam logic [3:0] S_CHK  = 4'd7;
	localparam logic [3:0] S_OP   = 4'd8;
	localparam logic [3:0] S_WAIT = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;

	localparam logic [3:0] ST_X    = 4'd0;
	localparam logic [3:0] ST_X2   = 4'd1;
	localparam logic [3:0] ST_X3   = 4'd2;
	localparam logic [3:0] ST_A1   = 4'd3;
	localparam logic [3:0] ST_B1   = 4'd4;
	localparam logic [3:0] ST_COEF = 4'd5;
	localparam logic [3:0] ST_T1   = 4'd6;
	localparam logic [3:0] ST_T2   = 4'd7;
	localparam logic [3:0] ST_T3   = 4'd8;
	localparam logic [3:0] ST_U    = 4'd9;
	localparam logic [3:0] ST_W    = 4'd10;
	localparam logic [3:0] ST_V    = 4'd11;

	logic [3:0]         state_q, step_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q, j_q, ind_q;
	logic [47:0]        t_q, tj_q, tn_q;
	logic               brk_q;
	logic [1:0]         k_q;
	logic signed [39:0] p0_q [3];
	logic signed [39:0] p1_q [3];
	logic signed [39:0] v0_q [3];
	logic signed [39:0] v1_q [3];
	logic signed [39:0] rpos_q [3];
	logic signed [39:0] rvel_q [3];
	logic signed [63:0] x_q, x2_q, x3_q, a1_q, b1_q, a2_q, a3_q, s_q;
	logic               out_valid_q, brk_out_q;
	logic signed [39:0] opos_q [3];
	logic signed [39:0] ovel_q [3];

	logic               acc_in, ld_we, hit, more, out_free;
	logic [IDX_W-1:0]   t_raddr, pv_raddr;
	logic [47:0]        t_rd, dt;
	logic [119:0]       pos_rd, vel_rd;
	logic signed [63:0] dd, p0k, p1k, v0k, v1k, dp, a2_d, a3_d, r;
	ohi_op_t            op;
	logic signed [63:0] opa, opb;
	logic               ar_done;

	assign in_stall = state_q != S_IDLE;
	assign acc_in   = in_valid && !in_stall;
	assign ld_we    = acc_in && cmd == CMD_LOAD && count_q < CNT_W'(MAX_RECORDS);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		case (state_q)
			S_W0:    t_raddr = j_q;
			S_W1:    t_raddr = j_q + IDX_W'(1);
			S_W2:    t_raddr = j_q + IDX_W'(2);
			S_F1:    t_raddr = ind_q + IDX_W'(1);
			default: t_raddr = ind_q;
		endcase
	end
	assign pv_raddr = (state_q == S_F1) ? ind_q + IDX_W'(1) : ind_q;

	ohi_ram #(.WIDTH(48), .DEPTH(MAX_RECORDS)) u_times (
		.clk(clk), .we(ld_we), .waddr(count_q[IDX_W-1:0]), .wdata(sample_time),
		.raddr(t_raddr), .rdata(t_rd)
	);
	ohi_ram #(.WIDTH(120), .DEPTH(MAX_RECORDS)) u_pos (
		.clk(clk), .we(ld_we), .waddr(count_q[IDX_W-1:0]),
		.wdata({in_pos_z, in_pos_y, in_pos_x}), .raddr(pv_raddr), .rdata(pos_rd)
	);
	ohi_ram #(.WIDTH(120), .DEPTH(MAX_RECORDS)) u_vel (
		.clk(clk), .we(ld_we), .waddr(count_q[IDX_W-1:0]),
		.wdata({in_vel_z, in_vel_y, in_vel_x}), .raddr(pv_raddr), .rdata(vel_rd)
	);

	// The walk compares against the time just read for record j+1.
	assign hit  = (t_q > tj_q) && (t_q <= t_rd);
	assign more = ({1'b0, j_q} + CNT_W'(2)) < count_q;

	assign dt  = tn_q - tj_q;
	assign dd  = $signed({16'b0, t_q}) - $signed({16'b0, tj_q});
	assign p0k = ohi_sx40(p0_q[k_q]);
	assign p1k = ohi_sx40(p1_q[k_q]);
	assign v0k = ohi_sx40(v0_q[k_q]);
	assign v1k = ohi_sx40(v1_q[k_q]);
	assign dp  = p1k - p0k;
	assign a2_d = ohi_sadd(ohi_sadd(dp + dp + dp, -ohi_sadd(a1_q, a1_q)), -b1_q);
	assign a3_d = ohi_sadd(ohi_sadd(-(dp + dp), a1_q), b1_q);

	always_comb begin
		op.start  = (state_q == S_OP) && step_q != ST_COEF;
		op.is_div = step_q == ST_X || step_q == ST_V;
		op.sh30   = !(step_q == ST_A1 || step_q == ST_B1 || step_q == ST_V);
		case (step_q)
			ST_X:    begin opa = dd;   opb = $signed({16'b0, dt}); end
			ST_X2:   begin opa = x_q;  opb = x_q;  end
			ST_X3:   begin opa = x2_q; opb = x_q;  end
			ST_A1:   begin opa = v0k;  opb = $signed({16'b0, dt}); end
			ST_B1:   begin opa = v1k;  opb = $signed({16'b0, dt}); end
			ST_T1:   begin opa = a1_q; opb = x_q;  end
			ST_T2:   begin opa = a2_q; opb = x2_q; end
			ST_T3:   begin opa = a3_q; opb = x3_q; end
			ST_U:    begin opa = a2_q; opb = x_q;  end
			ST_W:    begin opa = a3_q; opb = x2_q; end
			ST_V:    begin opa = s_q;  opb = $signed({16'b0, dt}); end
			default: begin opa = x_q;  opb = x_q;  end
		endcase
	end

	ohi_arith u_arith (
		.clk(clk), .arst_n(arst_n), .op(op), .opa(opa), .opb(opb),
		.res(r), .done(ar_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						case (cmd)
							CMD_LOAD: begin
								if (ld_we) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_CLEAR: begin
								count_q <= '0;
								idx_q   <= '0;
							end
							CMD_QUERY: begin
								if (count_q < CNT_W'(2)) begin
									state_q <= S_DONE;
								end else begin
									if (({1'b0, idx_q} + CNT_W'(1)) >= count_q) begin
										idx_q <= '0;
									end
									state_q <= S_W0;
								end
							end
							default: ;
						endcase
					end
				end
				S_W0: state_q <= S_W1;
				S_W1: state_q <= S_W2;
				S_W2: begin
					if (hit) begin
						idx_q   <= j_q;
						state_q <= S_F0;
					end else if (!more) begin
						state_q <= S_F0;
					end
				end
				S_F0: state_q <= S_F1;
				S_F1: state_q <= S_F2;
				S_F2: state_q <= S_CHK;
				S_CHK: state_q <= (tn_q <= tj_q) ? S_DONE : S_OP;
				S_OP: begin
					if (step_q != ST_COEF) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (ar_done) begin
						state_q <= (step_q == ST_V && k_q == 2'd2) ? S_DONE : S_OP;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				t_q   <= sample_time;
				brk_q <= 1'b0;
				j_q   <= (({1'b0, idx_q} + CNT_W'(1)) >= count_q) ? '0 : idx_q;
				for (int i = 0; i < 3; i++) begin
					rpos_q[i] <= '0;
					rvel_q[i] <= '0;
				end
			end
			S_W1: tj_q <= t_rd;
			S_W2: begin
				if (hit) begin
					ind_q <= j_q;
					brk_q <= 1'b1;
				end else if (more) begin
					tj_q <= t_rd;
					j_q  <= j_q + IDX_W'(1);
				end else begin
					ind_q <= idx_q;
				end
			end
			S_F1: begin
				tj_q <= t_rd;
				for (int i = 0; i < 3; i++) begin
					p0_q[i] <= pos_rd[40*i +: 40];
					v0_q[i] <= vel_rd[40*i +: 40];
				end
			end
			S_F2: begin
				tn_q <= t_rd;
				for (int i = 0; i < 3; i++) begin
					p1_q[i] <= pos_rd[40*i +: 40];
					v1_q[i] <= vel_rd[40*i +: 40];
				end
			end
			S_CHK: begin
				step_q <= ST_X;
				k_q    <= '0;
				for (int i = 0; i < 3; i++) begin
					rpos_q[i] <= p0_q[i];
					rvel_q[i] <= v0_q[i];
				end
			end
			S_OP: begin
				if (step_q == ST_COEF) begin
					a2_q   <= a2_d;
					a3_q   <= a3_d;
					step_q <= ST_T1;
				end
			end
			S_WAIT: begin
				if (ar_done) begin
					step_q <= step_q + 4'd1;
					case (step_q)
						ST_X:  x_q  <= r;
						ST_X2: x2_q <= r;
						ST_X3: x3_q <= r;
						ST_A1: a1_q <= r;
						ST_B1: b1_q <= r;
						ST_T1: s_q  <= ohi_sadd(p0k, r);
						ST_T2: s_q  <= ohi_sadd(s_q, r);
						ST_T3: rpos_q[k_q] <= ohi_clamp40(ohi_sadd(s_q, r));
						ST_U:  s_q  <= ohi_sadd(a1_q, ohi_sadd(r, r));
						ST_W:  s_q  <= ohi_sadd(s_q, ohi_sadd(ohi_sadd(r, r), r));
						ST_V: begin
							rvel_q[k_q] <= ohi_clamp40(r);
							step_q      <= ST_A1;
							k_q         <= k_q + 2'd1;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	// Output register: a finished result waits here while the next request
	// is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			brk_out_q <= brk_q;
			for (int i = 0; i < 3; i++) begin
				opos_q[i] <= rpos_q[i];
				ovel_q[i] <= rvel_q[i];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_pos_x = opos_q[0];
	assign out_pos_y = opos_q[1];
	assign out_pos_z = opos_q[2];
	assign out_vel_x = ovel_q[0];
	assign out_vel_y = ovel_q[1];
	assign out_vel_z = ovel_q[2];
	assign bracketed = brk_out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RECORDS))
		else $error("record count beyond table depth");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside the completion state");

	a_arith_done: assert property (@(posedge clk) disable iff (!arst_n)
		ar_done |-> state_q == S_WAIT)
		else $error("arithmetic unit finished with no operation pending");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_W2 |-> ({1'b0, j_q} + CNT_W'(1)) < count_q)
		else $error("bracket walk beyond the last loaded record");
endmodule
